// ===== hw/rtl/tsq_pkg.sv =====
// Shared types and constants for the TRNG sample qualifier.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tsq_pkg;

    localparam int WORD_W     = 32;
    localparam int POLL_W     = 20;
    localparam int RECOVERY_W = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [POLL_W-1:0]     MAX_POLLS_RESET      = 20'd480000;
    localparam logic [RECOVERY_W-1:0] MAX_RECOVERIES_RESET = 4'd3;

    localparam logic REG_MAX_POLLS      = 1'b0;
    localparam logic REG_MAX_RECOVERIES = 1'b1;

    typedef enum logic [1:0] {
        OUT_PENDING   = 2'd0,
        OUT_DELIVERED = 2'd1,
        OUT_FAILED    = 2'd2,
        OUT_IDLE      = 2'd3
    } outcome_t;

    typedef struct packed {
        logic              first;
        logic              seed_err_before;
        logic              clock_err;
        logic              ready_req;
        logic [WORD_W-1:0] word;
        logic              seed_err_after_read;
        logic              seed_err_after_flush;
    } in_item_t;

    typedef struct packed {
        outcome_t          outcome;
        logic [WORD_W-1:0] sample;
        logic              clear_clock_err;
        logic              flush_request;
    } out_item_t;

    typedef struct packed {
        logic              first;
        logic              seed_err;
        logic              clock_err;
        logic              ready_req;
        logic [WORD_W-1:0] word;
        logic              seed_err_after_flush;
    } poll_t;

    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic not_empty;
    } queue_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsq_if.sv =====
// Valid/ready channel interfaces for the poll input and the result output.
// Depends on tsq_pkg for the payload types.
`default_nettype none

interface tsq_in_if
    import tsq_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface tsq_out_if
    import tsq_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/trng_sample_qualifier_unit.sv =====
// Sustained rate is one poll transaction per clock cycle while the output
// side does not stall. Each poll gives exactly one result transaction, which
// passes the queue and the result register before it is offered. The back
// end's update of the request state per poll (recovery and poll counters,
// the 32-bit compare against the last delivered word) sets that rate; a
// two-entry queue between front and back end and the result register let
// either side stall without stopping the other. The user must write the
// budgets via APB only while no poll is in flight; the block does not enforce it.
//
// Top level of the TRNG sample qualifier: APB register file, front end,
// queue and back end. Depends on tsq_pkg, tsq_if and the tsq_* modules.
`default_nettype none

module trng_sample_qualifier_unit
    import tsq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    tsq_in_if.sink                     in_ch,
    tsq_out_if.source                  out_ch
);

    logic [POLL_W-1:0]     max_polls_reg;
    logic [RECOVERY_W-1:0] max_recoveries_reg;
    logic                  wr_en;
    queue_ctrl_t           qctl;
    poll_t                 front_poll;
    poll_t                 head_poll;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_MAX_POLLS:      prdata = APB_DATA_W'(max_polls_reg);
            REG_MAX_RECOVERIES: prdata = APB_DATA_W'(max_recoveries_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_polls_reg      <= MAX_POLLS_RESET;
            max_recoveries_reg <= MAX_RECOVERIES_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_MAX_POLLS:      max_polls_reg      <= pwdata[POLL_W-1:0];
                REG_MAX_RECOVERIES: max_recoveries_reg <= pwdata[RECOVERY_W-1:0];
                default:            max_polls_reg      <= max_polls_reg;
            endcase
        end
    end

    tsq_front u_front (
        .in_ch      (in_ch),
        .queue_full (qctl.full),
        .push       (qctl.push),
        .poll       (front_poll)
    );

    tsq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (qctl.push),
        .push_poll (front_poll),
        .pop       (qctl.pop),
        .full      (qctl.full),
        .not_empty (qctl.not_empty),
        .head      (head_poll)
    );

    tsq_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_polls      (max_polls_reg),
        .max_recoveries (max_recoveries_reg),
        .poll_valid     (qctl.not_empty),
        .poll           (head_poll),
        .pop            (qctl.pop),
        .out_ch         (out_ch)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tsq_front.sv =====
// Front end: accepts poll transactions and classifies each into a queue entry.
// Depends on tsq_pkg and tsq_in_if.
`default_nettype none

module tsq_front
    import tsq_pkg::*;
(
    tsq_in_if.sink     in_ch,
    input  wire logic  queue_full,
    output logic       push,
    output poll_t      poll
);

    logic word_zero;

    assign word_zero   = (in_ch.item.word == '0);
    assign in_ch.ready = !queue_full;
    assign push        = in_ch.valid && !queue_full;

    always_comb
    begin
        poll.first                = in_ch.item.first;
        poll.seed_err             = in_ch.item.seed_err_before
                                    || (in_ch.item.ready_req
                                        && (word_zero || in_ch.item.seed_err_after_read));
        poll.clock_err            = in_ch.item.clock_err;
        poll.ready_req            = in_ch.item.ready_req;
        poll.word                 = in_ch.item.word;
        poll.seed_err_after_flush = in_ch.item.seed_err_after_flush;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tsq_queue.sv =====
// Two-entry queue of classified polls between the front and back ends.
// Depends on tsq_pkg.
`default_nettype none

module tsq_queue
    import tsq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire poll_t push_poll,
    input  wire logic  pop,
    output logic       full,
    output logic       not_empty,
    output poll_t      head
);

    poll_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_poll;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QUEUE_CNT_W'(QUEUE_DEPTH))
        |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== hw/rtl/tsq_back.sv =====
// Back end: request state, recovery and poll budgets, continuous test and
// the registered result stage. Depends on tsq_pkg and tsq_out_if.
`default_nettype none

module tsq_back
    import tsq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [POLL_W-1:0]     max_polls,
    input  wire logic [RECOVERY_W-1:0] max_recoveries,
    input  wire logic                  poll_valid,
    input  wire poll_t                 poll,
    output logic                       pop,
    tsq_out_if.source                  out_ch
);

    logic [WORD_W-1:0]     last_word_reg;
    logic [WORD_W-1:0]     last_word_next;
    logic [POLL_W-1:0]     poll_count_reg;
    logic [POLL_W-1:0]     poll_count_next;
    logic [RECOVERY_W-1:0] recovery_count_reg;
    logic [RECOVERY_W-1:0] recovery_count_next;
    logic                  active_reg;
    logic                  active_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_item_reg;
    out_item_t             result;

    logic                  act;
    logic [POLL_W-1:0]     pc;
    logic [RECOVERY_W-1:0] rc;
    logic [RECOVERY_W-1:0] rc_inc;
    logic [POLL_W:0]       pc_inc;
    logic [POLL_W:0]       limit;
    logic                  fail;
    logic                  delivered;

    assign pop          = poll_valid && (!out_valid_reg || out_ch.ready);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_item_reg;

    assign act    = poll.first || active_reg;
    assign pc     = poll.first ? '0 : poll_count_reg;
    assign rc     = poll.first ? '0 : recovery_count_reg;
    assign rc_inc = rc + 1'b1;
    assign pc_inc = {1'b0, pc} + 1'b1;
    assign limit  = (max_polls == '0) ? (POLL_W+1)'(1) : {1'b0, max_polls};

    always_comb
    begin
        last_word_next         = last_word_reg;
        poll_count_next        = pc;
        recovery_count_next    = rc;
        active_next            = act;
        fail                   = 1'b0;
        delivered              = 1'b0;
        result.outcome         = OUT_PENDING;
        result.sample          = '0;
        result.clear_clock_err = poll.clock_err;
        result.flush_request   = 1'b0;

        if (!act)
        begin
            result.outcome         = OUT_IDLE;
            result.clear_clock_err = 1'b0;
        end
        else
        begin
            if (poll.seed_err)
            begin
                if (rc >= max_recoveries)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    recovery_count_next  = rc_inc;
                    result.flush_request = 1'b1;
                    if (poll.seed_err_after_flush && (rc_inc >= max_recoveries))
                    begin
                        fail = 1'b1;
                    end
                end
            end
            else if (poll.ready_req && (poll.word != last_word_reg))
            begin
                delivered      = 1'b1;
                last_word_next = poll.word;
                result.sample  = poll.word;
                result.outcome = OUT_DELIVERED;
                active_next    = 1'b0;
            end

            if (!delivered && !fail)
            begin
                if (pc_inc >= limit)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    poll_count_next = pc_inc[POLL_W-1:0];
                end
            end

            if (fail)
            begin
                result.outcome = OUT_FAILED;
                active_next    = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_word_reg      <= '0;
            poll_count_reg     <= '0;
            recovery_count_reg <= '0;
            active_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                last_word_reg      <= last_word_next;
                poll_count_reg     <= poll_count_next;
                recovery_count_reg <= recovery_count_next;
                active_reg         <= active_next;
            end
        end
    end

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.outcome == OUT_IDLE
        |-> out_item_reg.sample == '0 && !out_item_reg.flush_request
            && !out_item_reg.clear_clock_err)
        else $error("idle result carries data");

    a_sample_only_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.outcome != OUT_DELIVERED
        |-> out_item_reg.sample == '0)
        else $error("sample set without delivery");

    a_deliver_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        pop && delivered |=> !active_reg && last_word_reg == $past(poll.word))
        else $error("delivery did not close the request");

    a_no_flush_on_delivery: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.flush_request
        |-> out_item_reg.outcome != OUT_DELIVERED)
        else $error("flush requested with a delivered sample");

endmodule

`default_nettype wire
